@@ design/byte_stack_multi_transfer_unit_defines.svh @@
// Assertion macros for the byte stack transfer unit.
// Each macro expects a signal named clock in its scope; BSMT_ASSERT also needs reset.
`ifndef BYTE_STACK_MULTI_TRANSFER_UNIT_DEFINES_SVH
`define BYTE_STACK_MULTI_TRANSFER_UNIT_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define BSMT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define BSMT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/bsmt_pkg.sv @@
`default_nettype none

package bsmt_pkg;

   // Default sizing
   localparam int CAPACITY_DEF     = 256;
   localparam int MAX_TRANSFER_DEF = 8;

   // Fixed field widths
   localparam int LANES      = 8;
   localparam int LANE_SEL_W = 3;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 64;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // Access control from the top level to the byte store
   typedef struct packed {
      logic             en;      // advance: write allowed, read register loads
      logic             write;   // accepted push that passed the overflow check
      logic [LEN_W-1:0] length;  // bytes in this transfer
   } xfer_ctl_type;

endpackage

`default_nettype wire

@@ design/bsmt_if.sv @@
`default_nettype none

// Request channel
interface bsmt_req_if;
   import bsmt_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [LEN_W-1:0]  length;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output kind, output length, output write_data,
                   input ready);
   modport sink   (input valid, input kind, input length, input write_data,
                   output ready);
endinterface

// Result channel
interface bsmt_rsp_if;
   import bsmt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   read_data;
   logic [FILL_W-1:0]   fill_level;

   modport source (output valid, output status, output read_data, output fill_level,
                   input ready);
   modport sink   (input valid, input status, input read_data, input fill_level,
                   output ready);
endinterface

`default_nettype wire

@@ design/byte_stack_multi_transfer_unit.sv @@
// Byte stack with push, pop and peek transfers of up to eight bytes.
// Each result passes through the stage 1 registers and then the result register.
// Throughput: one item per cycle while the result side takes items; the
//   banked store reads and writes each of its eight banks once per cycle.
// Reset: synchronous; clears the fill level and both pipeline valids.
//   Stack contents are not cleared and are undefined until pushed.
`default_nettype none

module byte_stack_multi_transfer_unit #(
   parameter int CAPACITY     = bsmt_pkg::CAPACITY_DEF,
   parameter int MAX_TRANSFER = bsmt_pkg::MAX_TRANSFER_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   bsmt_req_if.sink    req_chan,
   bsmt_rsp_if.source  rsp_chan
);
   import bsmt_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int SUM_W  = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;
   localparam logic [SUM_W-1:0] TOP_LIMIT = SUM_W'(CAPACITY - 1);
   localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_TRANSFER);

   // Handshake
   logic advance;
   logic accept;

   // Request decode
   logic              is_push;
   logic              is_read;
   logic [LEN_W-1:0]  len_sat;
   logic [SUM_W-1:0]  top_ext;
   logic [SUM_W-1:0]  len_ext;
   logic [SUM_W-1:0]  push_sum;
   logic [SUM_W-1:0]  pop_base;
   logic              overflow;
   logic              underflow;
   logic [ADDR_W-1:0] base;
   logic [ADDR_W+FILL_W-1:0] fill_ext;

   // Fill level
   logic [ADDR_W-1:0] top_ff;
   logic [ADDR_W-1:0] top_in;

   // Stage 1: decoded item, waiting on bank read data
   logic                  s1_valid_ff;
   logic [STATUS_W-1:0]   s1_status_ff;
   logic [STATUS_W-1:0]   s1_status_in;
   logic [FILL_W-1:0]     s1_fill_ff;
   logic [LEN_W-1:0]      s1_len_ff;
   logic [LEN_W-1:0]      s1_len_in;
   logic [LANE_SEL_W-1:0] s1_rot_ff;
   logic [ADDR_W+LANE_SEL_W-1:0] base_wide;

   // Stage 2: result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic [DATA_W-1:0]   rsp_data_in;
   logic [FILL_W-1:0]   rsp_fill_ff;

   // Store interface
   xfer_ctl_type                  store_ctl;
   logic [LANES-1:0][BYTE_W-1:0]  lane_rd;

   // Pipeline moves when the result register is free or being taken
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && advance;
   assign req_chan.ready = advance;

   // Checks and new fill level
   always_comb begin
      is_push   = (req_chan.kind == KIND_PUSH);
      is_read   = (req_chan.kind == KIND_POP) || (req_chan.kind == KIND_PEEK);
      len_sat   = (req_chan.length > MAX_LEN) ? MAX_LEN : req_chan.length;
      top_ext   = {{(SUM_W-ADDR_W){1'b0}}, top_ff};
      len_ext   = {{(SUM_W-LEN_W){1'b0}}, len_sat};
      push_sum  = top_ext + len_ext;
      pop_base  = top_ext - len_ext;
      overflow  = is_push && (push_sum > TOP_LIMIT);
      underflow = is_read && (len_ext > top_ext);
      base      = is_push ? top_ff : pop_base[ADDR_W-1:0];

      top_in = top_ff;
      if (is_push && !overflow) begin
         top_in = push_sum[ADDR_W-1:0];
      end else if ((req_chan.kind == KIND_POP) && !underflow) begin
         top_in = pop_base[ADDR_W-1:0];
      end

      priority if (overflow) begin
         s1_status_in = STATUS_OVERFLOW;
      end else if (underflow) begin
         s1_status_in = STATUS_UNDERFLOW;
      end else begin
         s1_status_in = STATUS_OK;
      end

      s1_len_in = (is_read && !underflow) ? len_sat : '0;
      fill_ext  = {{FILL_W{1'b0}}, top_in};
      base_wide = {{LANE_SEL_W{1'b0}}, base};
   end

   assign store_ctl.en     = advance;
   assign store_ctl.write  = accept && is_push && !overflow;
   assign store_ctl.length = len_sat;

   bsmt_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .base    (base),
      .wdata   (req_chan.write_data),
      .lane_rd (lane_rd)
   );

   // Fill level register
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (accept) begin
         top_ff <= top_in;
      end
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_status_ff <= s1_status_in;
         s1_fill_ff   <= fill_ext[FILL_W-1:0];
         s1_len_ff    <= accept ? s1_len_in : '0;
         s1_rot_ff    <= base_wide[LANE_SEL_W-1:0];
      end
   end

   // Rotate bank bytes into address order, zero past the length
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rsp_data_in[BYTE_W*i +: BYTE_W] =
            (LEN_W'(i) < s1_len_ff) ? lane_rd[LANE_SEL_W'(s1_rot_ff + LANE_SEL_W'(i))]
                                    : '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= s1_status_ff;
         rsp_data_ff   <= rsp_data_in;
         rsp_fill_ff   <= s1_fill_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_data  = rsp_data_ff;
   assign rsp_chan.fill_level = rsp_fill_ff;

endmodule

`default_nettype wire

@@ design/bsmt_store.sv @@
`default_nettype none

// Byte store split into eight interleaved banks: address a lives in bank a mod 8,
// row a / 8. Eight consecutive bytes touch each bank at most once.
module bsmt_store #(
   parameter  int CAPACITY = bsmt_pkg::CAPACITY_DEF,
   localparam int ADDR_W   = $clog2(CAPACITY)
) (
   input  wire logic                                        clock,
   input  wire bsmt_pkg::xfer_ctl_type                      ctl,
   input  wire logic [ADDR_W-1:0]                           base,
   input  wire logic [bsmt_pkg::DATA_W-1:0]                 wdata,
   output logic [bsmt_pkg::LANES-1:0][bsmt_pkg::BYTE_W-1:0] lane_rd
);
   import bsmt_pkg::*;

   localparam int ROWS  = (CAPACITY + LANES - 1) / LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ADDR_W+LANE_SEL_W-1:0] base_ext;
   logic [ROW_W-1:0]             base_row;
   logic [LANE_SEL_W-1:0]        base_lo;

   // Split the start address into row and starting bank
   assign base_ext = {{LANE_SEL_W{1'b0}}, base};
   assign base_lo  = base_ext[LANE_SEL_W-1:0];
   assign base_row = ROW_W'(base_ext >> LANE_SEL_W);

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [BYTE_W-1:0]     mem [ROWS];
      logic [BYTE_W-1:0]     rd_ff;
      logic [LANE_SEL_W-1:0] offset;
      logic [ROW_W-1:0]      row;
      logic                  used;
      logic [BYTE_W-1:0]     wbyte;

      // Offset of this bank within the transfer; banks below the start wrap a row
      assign offset = LANE_SEL_W'(LANE_SEL_W'(b) - base_lo);
      assign row    = base_row + ROW_W'(LANE_SEL_W'(b) < base_lo);
      assign used   = {1'b0, offset} < ctl.length;
      assign wbyte  = wdata[BYTE_W*offset +: BYTE_W];

      always_ff @(posedge clock) begin
         if (ctl.en && ctl.write && used) begin
            mem[row] <= wbyte;
         end
         if (ctl.en) begin
            rd_ff <= mem[row];
         end
      end

      assign lane_rd[b] = rd_ff;
   end

endmodule

`default_nettype wire

@@ design/bsmt_checker.sv @@
`default_nettype none

`include "byte_stack_multi_transfer_unit_defines.svh"

module bsmt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [bsmt_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [bsmt_pkg::FILL_W-1:0]   rsp_fill
);
   import bsmt_pkg::*;

   logic [1:0]        outstanding_ff;
   logic [1:0]        outstanding_in;
   logic [FILL_W-1:0] last_fill_ff;
   logic              req_take;
   logic              rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Items accepted but not yet delivered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         last_fill_ff   <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
         if (rsp_take) begin
            last_fill_ff <= rsp_fill;
         end
      end
   end

   `BSMT_ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid,
                       "result valid after reset")
   `BSMT_ASSERT(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid,
                "result dropped while stalled")
   `BSMT_ASSERT(a_rsp_has_item, rsp_valid |-> (outstanding_ff != 2'd0),
                "result without request")
   `BSMT_ASSERT(a_depth, outstanding_ff != 2'd3,
                "more items in flight than pipeline stages")
   `BSMT_ASSERT(a_reject_keeps_fill,
                rsp_valid && (rsp_status != STATUS_OK) |-> rsp_fill == last_fill_ff,
                "rejected item changed fill level")

endmodule

bind byte_stack_multi_transfer_unit bsmt_checker u_bsmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_fill   (rsp_chan.fill_level)
);

`default_nettype wire
